/* hw/rtl/anb_pkg.sv */
// shared types, constants and codes for the annex b nal unit scanner
package anb_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned OUT_W             = 32;
  localparam int unsigned CNT_W             = 32;
  localparam int unsigned HDR_W             = 16;
  localparam int unsigned SCLEN_W           = 3;
  localparam int unsigned TYPE_W            = 6;
  localparam int unsigned LAYER_W           = 6;
  localparam int unsigned TID_W             = 3;

  localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [23:0]        NO_ZEROS  = 24'hFFFFFF;
  localparam logic [7:0]         SC_BYTE   = 8'h01;
  localparam logic [SCLEN_W-1:0] SC_LEN3   = 3'd3;
  localparam logic [SCLEN_W-1:0] SC_LEN4   = 3'd4;

  typedef enum logic [1:0] {
    LAYOUT_AVC  = 2'd0,
    LAYOUT_HEVC = 2'd1,
    LAYOUT_VVC  = 2'd2,
    LAYOUT_OBU  = 2'd3
  } codec_t;

  typedef struct packed {
    logic [OUT_W-1:0]   offset;
    logic [CNT_W-1:0]   size;
    logic [SCLEN_W-1:0] sc_len;
    logic [HDR_W-1:0]   hdr;
  } scan_rpt_t;

  typedef struct packed {
    logic [OUT_W-1:0]   offset;
    logic [CNT_W-1:0]   size;
    logic [SCLEN_W-1:0] sc_len;
    logic [TYPE_W-1:0]  unit_type;
    logic [LAYER_W-1:0] nuh_layer;
    logic [TID_W-1:0]   tid_plus1;
    logic               complete;
  } unit_rpt_t;

endpackage

/* hw/rtl/annexb_nal_unit_scanner.sv */
// top level of the annex b nal unit scanner
// Usage:
//   in_ channel: one buffer byte per beat, in_last_byte marks the buffer's final
//   byte; after it the position and unit tracking start over at offset zero.
//   out_ channel: one beat per reported unit (offset, size, start code length
//   and decoded header fields); empty units and bytes before the first start
//   code give no beat.
//   cfg_wr_en / cfg_wr_data: header layout select, written while the block is idle.
// Throughput: one byte per clock while in_stall is low; the scan state updates on each taken byte.
// A unit's beat is written into the result buffer with the byte that closes it
//   (the next start code's 01 byte or the buffer's final byte) and shows on out_ once earlier beats are taken.
// A two-entry result buffer sits before out_: in_stall rises only when both
//   entries hold beats, so a stall on out_ reaches the input after two units
//   are waiting. Stalled out_ beats hold their payload.
// Reset (rst_n low, synchronous) empties the buffer, clears the scan state and
//   sets the layout select to H.264.
module annexb_nal_unit_scanner import anb_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   out_unit_offset,
  output logic [CNT_W-1:0]   out_unit_size,
  output logic [SCLEN_W-1:0] out_start_code_length,
  output logic [TYPE_W-1:0]  out_unit_type,
  output logic [LAYER_W-1:0] out_nuh_layer,
  output logic [TID_W-1:0]   out_temporal_id_plus1,
  output logic               out_header_complete
);

  codec_t    codec_r;
  logic      take;
  logic      emit;
  logic      full;
  scan_rpt_t raw;
  unit_rpt_t dec;
  unit_rpt_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= LAYOUT_AVC;
    end else if (cfg_wr_en) begin
      codec_r <= codec_t'(cfg_wr_data);
    end
  end

  assign in_stall = full;
  assign take     = in_valid && !full;

  anb_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .byte_value (in_byte_value),
    .last_byte  (in_last_byte),
    .emit       (emit),
    .rpt        (raw)
  );

  anb_hdr_dec u_hdr_dec (
    .codec (codec_r),
    .raw   (raw),
    .dec   (dec)
  );

  anb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (dec),
    .full      (full),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (head)
  );

  assign out_unit_offset       = head.offset;
  assign out_unit_size         = head.size;
  assign out_start_code_length = head.sc_len;
  assign out_unit_type         = head.unit_type;
  assign out_nuh_layer         = head.nuh_layer;
  assign out_temporal_id_plus1 = head.tid_plus1;
  assign out_header_complete   = head.complete;

endmodule

/* hw/rtl/anb_scan.sv */
// start code search and unit tracking, one byte per beat
module anb_scan import anb_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] byte_value,
  input  logic      last_byte,
  output logic      emit,
  output scan_rpt_t rpt
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_off_r, start_off_nxt;
  logic [23:0]              recent_r, recent_nxt;
  logic                     in_unit_r, in_unit_nxt;
  logic [SCLEN_W-1:0]       sc_len_r, sc_len_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [HDR_W-1:0]         hdr_r, hdr_nxt;

  logic                     is_sc;
  logic [SCLEN_W-1:0]       new_len;
  logic [SCLEN_W-1:0]       len_m1;
  logic [CNT_W-1:0]         sc_size;
  logic [CNT_W-1:0]         upd_count;
  logic [HDR_W-1:0]         upd_hdr;

  always_comb begin
    is_sc   = (byte_value == SC_BYTE) && (recent_r[15:0] == 16'h0000);
    new_len = (recent_r[23:16] == 8'h00) ? SC_LEN4 : SC_LEN3;
    len_m1  = new_len - 3'd1;
    sc_size = (count_r == COUNT_MAX) ? COUNT_MAX : count_r - CNT_W'(len_m1);

    upd_hdr = hdr_r;
    if (in_unit_r && count_r == '0) begin
      upd_hdr = {byte_value, 8'h00};
    end else if (in_unit_r && count_r == CNT_W'(1)) begin
      upd_hdr = {hdr_r[15:8], byte_value};
    end
    upd_count = count_r;
    if (in_unit_r && count_r != COUNT_MAX) begin
      upd_count = count_r + CNT_W'(1);
    end

    pos_nxt       = pos_r;
    start_off_nxt = start_off_r;
    recent_nxt    = recent_r;
    in_unit_nxt   = in_unit_r;
    sc_len_nxt    = sc_len_r;
    count_nxt     = count_r;
    hdr_nxt       = hdr_r;

    rpt.offset = OUT_W'(start_off_r);
    rpt.sc_len = sc_len_r;
    if (is_sc) begin
      rpt.size = sc_size;
      rpt.hdr  = hdr_r;
      emit     = take && in_unit_r && (sc_size != '0);
    end else begin
      rpt.size = upd_count;
      rpt.hdr  = upd_hdr;
      emit     = take && last_byte && in_unit_r && (upd_count != '0);
    end

    if (take) begin
      if (is_sc) begin
        in_unit_nxt   = 1'b1;
        start_off_nxt = pos_r - POSITION_BITS'(len_m1);
        sc_len_nxt    = new_len;
        count_nxt     = '0;
        hdr_nxt       = '0;
        recent_nxt    = NO_ZEROS;
      end else begin
        count_nxt  = upd_count;
        hdr_nxt    = upd_hdr;
        recent_nxt = {recent_r[15:0], byte_value};
      end
      if (last_byte) begin
        pos_nxt       = '0;
        recent_nxt    = NO_ZEROS;
        in_unit_nxt   = 1'b0;
        start_off_nxt = '0;
        sc_len_nxt    = SC_LEN3;
        count_nxt     = '0;
        hdr_nxt       = '0;
      end else begin
        pos_nxt = pos_r + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_off_r <= '0;
      recent_r    <= NO_ZEROS;
      in_unit_r   <= 1'b0;
      sc_len_r    <= SC_LEN3;
      count_r     <= '0;
      hdr_r       <= '0;
    end else begin
      pos_r       <= pos_nxt;
      start_off_r <= start_off_nxt;
      recent_r    <= recent_nxt;
      in_unit_r   <= in_unit_nxt;
      sc_len_r    <= sc_len_nxt;
      count_r     <= count_nxt;
      hdr_r       <= hdr_nxt;
    end
  end

endmodule

/* hw/rtl/anb_hdr_dec.sv */
// unit header field decode per codec layout
module anb_hdr_dec import anb_pkg::*; (
  input  codec_t    codec,
  input  scan_rpt_t raw,
  output unit_rpt_t dec
);

  logic [7:0] b0, b1;
  logic       two_bytes;

  always_comb begin
    b0        = raw.hdr[15:8];
    b1        = raw.hdr[7:0];
    two_bytes = |raw.size[CNT_W-1:1];

    dec.offset    = raw.offset;
    dec.size      = raw.size;
    dec.sc_len    = raw.sc_len;
    dec.unit_type = '0;
    dec.nuh_layer = '0;
    dec.tid_plus1 = '0;
    dec.complete  = 1'b1;

    unique case (codec)
      LAYOUT_AVC: begin
        dec.unit_type = {1'b0, b0[4:0]};
      end
      LAYOUT_HEVC: begin
        dec.unit_type = b0[6:1];
        if (two_bytes) begin
          dec.nuh_layer = {b0[0], b1[7:3]};
          dec.tid_plus1 = b1[2:0];
        end else begin
          dec.complete = 1'b0;
        end
      end
      LAYOUT_VVC: begin
        dec.nuh_layer = b0[5:0];
        if (two_bytes) begin
          dec.unit_type = {1'b0, b1[7:3]};
          dec.tid_plus1 = b1[2:0];
        end else begin
          dec.complete = 1'b0;
        end
      end
      LAYOUT_OBU: begin
        dec.unit_type = {2'b00, b0[6:3]};
      end
      default: begin
        dec.unit_type = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/anb_out_buf.sv */
// two-entry result buffer between the scanner and the result channel
module anb_out_buf import anb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  unit_rpt_t push_data,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop_stall,
  output unit_rpt_t pop_data
);

  logic      v0_r, v0_nxt, v1_r, v1_nxt;
  unit_rpt_t d0_r, d0_nxt, d1_r, d1_nxt;
  logic      pop;

  always_comb begin
    pop    = v0_r && !pop_stall;
    v0_nxt = pop ? v1_r : v0_r;
    v1_nxt = pop ? 1'b0 : v1_r;
    d0_nxt = pop ? d1_r : d0_r;
    d1_nxt = d1_r;
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        d0_nxt = push_data;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign full      = v1_r;
  assign pop_valid = v0_r;
  assign pop_data  = d0_r;

endmodule
